FILE: rtl/cqdn_pkg.sv
// ----------------------------------------------------------------------------
// cqdn_pkg: shared types and constants for the delete-at-position ring queue
// Queue depth, derived widths, result status codes and the command/status
// bundles exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package cqdn_pkg;

  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = 8;
  localparam int OCC_W = 4;
  localparam int DATA_W = 32;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [2:0] status_t;

  localparam status_t ST_ENQ    = 3'd0;
  localparam status_t ST_DEL    = 3'd1;
  localparam status_t ST_FULL   = 3'd2;
  localparam status_t ST_EMPTY  = 3'd3;
  localparam status_t ST_BADPOS = 3'd4;

  // Controller to datapath.
  typedef struct packed {
    logic    enq;        // append the input word at the tail
    logic    rej;        // post a rejection result, queue unchanged
    status_t rej_status;
    logic    del_start;  // read the head, load the rotation pointers
    logic    rot_step;   // move one word from head side to tail side
    logic    del_done;   // retire the word just read, post the result
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_bad;
    logic rem_zero;
  } stat_t;

endpackage

FILE: rtl/cqdn_datapath.sv
// ----------------------------------------------------------------------------
// cqdn_datapath: storage, pointers and result registers
// Holds the slot memory, head and count, the rotation pointers used while a
// delete is in progress, and the registered result fields.
// ----------------------------------------------------------------------------
module cqdn_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cqdn_pkg::cmd_t                       cmd,
  output cqdn_pkg::stat_t                      stat,
  input  logic signed [cqdn_pkg::DATA_W-1:0]   in_data_value,
  input  logic        [cqdn_pkg::POS_W-1:0]    in_position,
  output cqdn_pkg::status_t                    out_status,
  output logic signed [cqdn_pkg::DATA_W-1:0]   out_deleted_value,
  output logic        [cqdn_pkg::OCC_W-1:0]    out_occupancy
);

  localparam int IDX_W = cqdn_pkg::IDX_W;
  localparam int CNT_W = cqdn_pkg::CNT_W;
  localparam int CMP_W = cqdn_pkg::CMP_W;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    wrap_inc = (idx == IDX_W'(cqdn_pkg::DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  logic signed [cqdn_pkg::DATA_W-1:0] mem [cqdn_pkg::DEPTH];
  logic signed [cqdn_pkg::DATA_W-1:0] rd_data_r;

  logic [IDX_W-1:0]           head_r, head_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [IDX_W-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [IDX_W-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [cqdn_pkg::POS_W-1:0] rem_r, rem_nxt;

  logic [CNT_W:0]             tail_sum;
  logic [IDX_W-1:0]           tail;

  logic                       mem_we, mem_re;
  logic [IDX_W-1:0]           mem_wa, mem_ra;
  logic signed [cqdn_pkg::DATA_W-1:0] mem_wd;

  // Tail slot: head plus count, folded once.
  always_comb begin
    tail_sum = (CNT_W+1)'(head_r) + (CNT_W+1)'(count_r);
    if (tail_sum >= (CNT_W+1)'(cqdn_pkg::DEPTH)) begin
      tail = IDX_W'(tail_sum - (CNT_W+1)'(cqdn_pkg::DEPTH));
    end else begin
      tail = IDX_W'(tail_sum);
    end
  end

  assign stat.full     = (count_r == CNT_W'(cqdn_pkg::DEPTH));
  assign stat.empty    = (count_r == '0);
  assign stat.pos_bad  = (in_position == '0) ||
                         (CMP_W'(in_position) > CMP_W'(count_r));
  assign stat.rem_zero = (rem_r == '0);

  always_comb begin
    mem_we     = cmd.enq | cmd.rot_step;
    mem_wa     = cmd.enq ? tail : wr_ptr_r;
    mem_wd     = cmd.enq ? in_data_value : rd_data_r;
    mem_re     = cmd.del_start | cmd.rot_step;
    mem_ra     = cmd.del_start ? head_r : rd_ptr_r;

    head_nxt   = head_r;
    count_nxt  = count_r;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    rem_nxt    = rem_r;

    if (cmd.enq) begin
      count_nxt = count_r + 1'b1;
    end
    if (cmd.del_start) begin
      rd_ptr_nxt = wrap_inc(head_r);
      wr_ptr_nxt = tail;
      rem_nxt    = in_position - 1'b1;
    end
    if (cmd.rot_step) begin
      rd_ptr_nxt = wrap_inc(rd_ptr_r);
      wr_ptr_nxt = wrap_inc(wr_ptr_r);
      rem_nxt    = rem_r - 1'b1;
    end
    if (cmd.del_done) begin
      count_nxt = count_r - 1'b1;
      head_nxt  = (count_r == CNT_W'(1)) ? '0 : rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r <= rd_ptr_nxt;
    wr_ptr_r <= wr_ptr_nxt;
    rem_r    <= rem_nxt;
  end

  // Result fields: payload only, validity lives in the controller.
  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      out_status        <= cqdn_pkg::ST_ENQ;
      out_deleted_value <= '0;
      out_occupancy     <= cqdn_pkg::OCC_W'(count_nxt);
    end else if (cmd.rej) begin
      out_status        <= cmd.rej_status;
      out_deleted_value <= '0;
      out_occupancy     <= cqdn_pkg::OCC_W'(count_r);
    end else if (cmd.del_done) begin
      out_status        <= cqdn_pkg::ST_DEL;
      out_deleted_value <= rd_data_r;
      out_occupancy     <= cqdn_pkg::OCC_W'(count_nxt);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(cqdn_pkg::DEPTH))
    else $error("entry count above depth");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == '0))
    else $error("empty queue with nonzero head");

  a_step_rem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rot_step |-> (rem_r != '0))
    else $error("rotation step with no rotations left");

endmodule

FILE: rtl/cqdn_ctrl.sv
// ----------------------------------------------------------------------------
// cqdn_ctrl: sequencing for the delete-at-position ring queue
// Decodes accepted items, runs the rotation loop of a delete and owns the
// input stall and the result valid.
// ----------------------------------------------------------------------------
module cqdn_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_mode,
  output logic            out_valid,
  input  logic            out_stall,
  input  cqdn_pkg::stat_t stat,
  output cqdn_pkg::cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;
  logic accept;
  logic post;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && slot_free);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_mode) begin
            if (stat.full) begin
              cmd.rej        = 1'b1;
              cmd.rej_status = cqdn_pkg::ST_FULL;
            end else begin
              cmd.enq = 1'b1;
            end
          end else if (stat.empty) begin
            cmd.rej        = 1'b1;
            cmd.rej_status = cqdn_pkg::ST_EMPTY;
          end else if (stat.pos_bad) begin
            cmd.rej        = 1'b1;
            cmd.rej_status = cqdn_pkg::ST_BADPOS;
          end else begin
            cmd.del_start = 1'b1;
            state_nxt     = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (!stat.rem_zero) begin
          cmd.rot_step = 1'b1;
        end else if (slot_free) begin
          cmd.del_done = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign post = cmd.enq | cmd.rej | cmd.del_done;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (post) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    post |-> slot_free)
    else $error("result posted over an untaken result");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.enq, cmd.rej, cmd.del_start, cmd.rot_step, cmd.del_done}))
    else $error("conflicting datapath commands");

  a_run_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.del_done |=> (state_r == S_IDLE) && out_valid_r)
    else $error("delete finished without posting a result");

endmodule

FILE: rtl/circular_queue_delete_nth_top.sv
// ----------------------------------------------------------------------------
// circular_queue_delete_nth_top: ring queue of signed words with delete at
// a 1-based position
// Each transfer on the input is an enqueue (mode 0) or a delete at position n
// (mode 1) and yields exactly one result transfer. Enqueues and rejected items
// (full, empty, bad position) post their result when accepted, so a new item
// can follow on the next cycle once the result is taken. A delete at position
// n reads the head, carries the first n-1 entries from head to tail one word
// per cycle through the single read port and single write port of the slot
// memory, then retires the word at the head once the output register is free.
// The result sits in an output register, and the input is stalled during a
// delete and while that register holds a result that is not being taken; the
// next item can be taken in the same cycle as the waiting result. The slot
// memory needs no clearing after reset; only head and count are reset.
// ----------------------------------------------------------------------------
module circular_queue_delete_nth_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_mode,
  input  logic signed [cqdn_pkg::DATA_W-1:0]   in_data_value,
  input  logic        [cqdn_pkg::POS_W-1:0]    in_position,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [2:0]                    out_status,
  output logic signed [cqdn_pkg::DATA_W-1:0]   out_deleted_value,
  output logic        [cqdn_pkg::OCC_W-1:0]    out_occupancy
);

  // Commands flow down, flags flow back; nothing else crosses.
  cqdn_pkg::cmd_t  cmd;
  cqdn_pkg::stat_t stat;

  // Sequencer: accepts a transfer, decides its outcome and steps the
  // rotation of a delete until the target word has been read.
  cqdn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage and arithmetic: slot memory, head/count, rotation pointers
  // and the registered result payload.
  cqdn_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_data_value     (in_data_value),
    .in_position       (in_position),
    .out_status        (out_status),
    .out_deleted_value (out_deleted_value),
    .out_occupancy     (out_occupancy)
  );

endmodule
